[rtl/core/vcpm_pkg.sv]
// Package for the velocity command priority multiplexer.
// Holds the request, source and register codes and the structs shared by the modules.
// No dependencies.
`default_nettype none

package vcpm_pkg;

    // Request kinds carried in the input tuser field.
    localparam logic [3:0] REQ_TICK         = 4'd0;
    localparam logic [3:0] REQ_TELEOP_CMD   = 4'd1;
    localparam logic [3:0] REQ_WEB_CMD      = 4'd2;
    localparam logic [3:0] REQ_AUTO_CMD     = 4'd3;
    localparam logic [3:0] REQ_TELEOP_STS   = 4'd4;
    localparam logic [3:0] REQ_WEB_STS      = 4'd5;
    localparam logic [3:0] REQ_TELEOP_ESTOP = 4'd6;
    localparam logic [3:0] REQ_GATE         = 4'd7;
    localparam logic [3:0] REQ_GLOBAL_ESTOP = 4'd8;

    // Manual source status codes; anything from STS_ACTIVE upwards counts as active.
    localparam logic [1:0] STS_IDLE   = 2'd0;
    localparam logic [1:0] STS_ESTOP  = 2'd1;
    localparam logic [1:0] STS_ACTIVE = 2'd2;

    // Source codes of a result.
    localparam logic [3:0] SRC_ESTOP        = 4'd0;
    localparam logic [3:0] SRC_TELEOP       = 4'd1;
    localparam logic [3:0] SRC_TELEOP_STALE = 4'd2;
    localparam logic [3:0] SRC_TELEOP_HOLD  = 4'd3;
    localparam logic [3:0] SRC_AUTO         = 4'd4;
    localparam logic [3:0] SRC_AUTO_STALE   = 4'd5;
    localparam logic [3:0] SRC_WEB          = 4'd6;
    localparam logic [3:0] SRC_WEB_STALE    = 4'd7;
    localparam logic [3:0] SRC_WEB_HOLD     = 4'd8;
    localparam logic [3:0] SRC_GATE_CLOSED  = 4'd9;

    // Command slot and manual source indexes.
    localparam logic [1:0] CMD_TELEOP = 2'd0;
    localparam logic [1:0] CMD_WEB    = 2'd1;
    localparam logic [1:0] CMD_AUTO   = 2'd2;
    localparam logic       MAN_TELEOP = 1'b0;
    localparam logic       MAN_WEB    = 1'b1;

    // Register indexes (byte address is four times the index).
    localparam logic [1:0] REG_MANUAL_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_AUTO_TIMEOUT   = 2'd1;
    localparam logic [1:0] REG_RELEASE_HOLD   = 2'd2;
    localparam logic [1:0] REG_EMIT_PERIOD    = 2'd3;

    localparam int CFG_TICK_W   = 11;
    localparam int CFG_PERIOD_W = 7;

    typedef struct packed {
        logic [CFG_TICK_W-1:0]   manual_timeout_ticks;
        logic [CFG_TICK_W-1:0]   autonomy_timeout_ticks;
        logic [CFG_TICK_W-1:0]   release_hold_ticks;
        logic [CFG_PERIOD_W-1:0] emit_period_ticks;
    } cfg_t;

    typedef struct packed {
        logic [3:0]         req_type;
        logic signed [15:0] lin_vel;
        logic signed [15:0] ang_vel;
        logic               cmd_finite;
        logic [1:0]         status_code;
        logic               flag_value;
    } item_t;

    typedef struct packed {
        logic signed [15:0] out_lin_vel;
        logic signed [15:0] out_ang_vel;
        logic [3:0]         source_code;
    } result_t;

endpackage

`default_nettype wire

[rtl/core/vcpm_cfg_regs.sv]
// Configuration register file with an APB-style slave port.
// Clamps written values into their legal ranges. Depends on vcpm_pkg.
`default_nettype none

module vcpm_cfg_regs
    import vcpm_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    output cfg_t             cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;
    logic wr_en;
    logic [1:0] reg_idx;

    function automatic logic [CFG_TICK_W-1:0] clamp_tick(
        input logic [CFG_TICK_W-1:0] v,
        input logic [CFG_TICK_W-1:0] lo,
        input logic [CFG_TICK_W-1:0] hi
    );
        logic [CFG_TICK_W-1:0] r;
        if (v < lo) begin
            r = lo;
        end else if (v > hi) begin
            r = hi;
        end else begin
            r = v;
        end
        return r;
    endfunction

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_MANUAL_TIMEOUT: begin
                    cfg_next.manual_timeout_ticks =
                        clamp_tick(pwdata[CFG_TICK_W-1:0], 11'd50, 11'd2000);
                end
                REG_AUTO_TIMEOUT: begin
                    cfg_next.autonomy_timeout_ticks =
                        clamp_tick(pwdata[CFG_TICK_W-1:0], 11'd50, 11'd2000);
                end
                REG_RELEASE_HOLD: begin
                    cfg_next.release_hold_ticks =
                        clamp_tick(pwdata[CFG_TICK_W-1:0], 11'd0, 11'd2000);
                end
                REG_EMIT_PERIOD: begin
                    cfg_next.emit_period_ticks = CFG_PERIOD_W'(
                        clamp_tick({4'd0, pwdata[CFG_PERIOD_W-1:0]}, 11'd10, 11'd100));
                end
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.manual_timeout_ticks   <= 11'd300;
            cfg_reg.autonomy_timeout_ticks <= 11'd600;
            cfg_reg.release_hold_ticks     <= 11'd1000;
            cfg_reg.emit_period_ticks      <= 7'd20;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MANUAL_TIMEOUT: prdata = 32'(cfg_reg.manual_timeout_ticks);
            REG_AUTO_TIMEOUT:   prdata = 32'(cfg_reg.autonomy_timeout_ticks);
            REG_RELEASE_HOLD:   prdata = 32'(cfg_reg.release_hold_ticks);
            REG_EMIT_PERIOD:    prdata = 32'(cfg_reg.emit_period_ticks);
            default:            prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/vcpm_core.sv]
// Event register, source state and priority selection of the multiplexer.
// Applies one registered event per cycle and forms a result on emitting ticks. Depends on vcpm_pkg.
`default_nettype none

module vcpm_core
    import vcpm_pkg::*;
#(
    parameter int VEL_WIDTH = 16,
    parameter int AGE_WIDTH = 11
) (
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  item_load,
    input  item_t      item_in,
    input  cfg_t       cfg,
    output logic       item_pending,
    output logic       res_push,
    output result_t    res
);

    localparam logic [AGE_WIDTH-1:0] AGE_MAX = {AGE_WIDTH{1'b1}};
    localparam int CMP_W = (AGE_WIDTH > CFG_TICK_W) ? AGE_WIDTH : CFG_TICK_W;

    item_t item_reg;
    logic  item_valid_reg;

    logic [VEL_WIDTH-1:0] cmd_lin_reg [3];
    logic [VEL_WIDTH-1:0] cmd_ang_reg [3];
    logic [2:0]           cmd_valid_reg, cmd_valid_next;
    logic [2:0]           cmd_seen_reg, cmd_seen_next;
    logic [AGE_WIDTH-1:0] cmd_age_reg [3];
    logic [AGE_WIDTH-1:0] cmd_age_next [3];
    logic [1:0]           sts_code_reg [2];
    logic [1:0]           sts_code_next [2];
    logic [1:0]           sts_seen_reg, sts_seen_next;
    logic [AGE_WIDTH-1:0] sts_age_reg [2];
    logic [AGE_WIDTH-1:0] sts_age_next [2];
    logic [1:0]           src_active_reg, src_active_next;
    logic [1:0]           hold_armed_reg, hold_armed_next;
    logic [AGE_WIDTH-1:0] hold_age_reg [2];
    logic [AGE_WIDTH-1:0] hold_age_next [2];
    logic                 tele_estop_reg, tele_estop_next;
    logic                 glob_estop_reg, glob_estop_next;
    logic                 gate_open_reg, gate_open_next;
    logic                 gate_seen_reg, gate_seen_next;
    logic [CFG_PERIOD_W-1:0] emit_cnt_reg, emit_cnt_next, emit_cnt_inc;

    logic       take_cmd;
    logic [1:0] cmd_idx;
    logic       take_sts;
    logic       sts_idx;
    logic       sts_act;
    logic       emit;

    function automatic logic [AGE_WIDTH-1:0] age_up(input logic [AGE_WIDTH-1:0] a);
        return (a == AGE_MAX) ? a : a + 1'b1;
    endfunction

    function automatic logic within_limit(
        input logic [AGE_WIDTH-1:0]  age,
        input logic [CFG_TICK_W-1:0] limit
    );
        return (age != AGE_MAX) && (CMP_W'(age) <= CMP_W'(limit));
    endfunction

    assign item_pending = item_valid_reg;

    // Event register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else begin
            item_valid_reg <= item_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (item_load) begin
            item_reg <= item_in;
        end
    end

    // Next state for the registered event.
    always_comb begin
        cmd_valid_next  = cmd_valid_reg;
        cmd_seen_next   = cmd_seen_reg;
        sts_seen_next   = sts_seen_reg;
        src_active_next = src_active_reg;
        hold_armed_next = hold_armed_reg;
        tele_estop_next = tele_estop_reg;
        glob_estop_next = glob_estop_reg;
        gate_open_next  = gate_open_reg;
        gate_seen_next  = gate_seen_reg;
        emit_cnt_next   = emit_cnt_reg;
        emit_cnt_inc    = emit_cnt_reg + 1'b1;
        emit            = 1'b0;
        take_cmd        = 1'b0;
        cmd_idx         = CMD_TELEOP;
        take_sts        = 1'b0;
        sts_idx         = MAN_TELEOP;
        sts_act         = item_reg.status_code >= STS_ACTIVE;
        for (int i = 0; i < 3; i++) begin
            cmd_age_next[i] = cmd_age_reg[i];
        end
        for (int i = 0; i < 2; i++) begin
            sts_code_next[i] = sts_code_reg[i];
            sts_age_next[i]  = sts_age_reg[i];
            hold_age_next[i] = hold_age_reg[i];
        end

        if (item_valid_reg) begin
            case (item_reg.req_type)
                REQ_TICK: begin
                    for (int i = 0; i < 3; i++) begin
                        cmd_age_next[i] = age_up(cmd_age_reg[i]);
                    end
                    for (int i = 0; i < 2; i++) begin
                        sts_age_next[i]  = age_up(sts_age_reg[i]);
                        hold_age_next[i] = age_up(hold_age_reg[i]);
                    end
                    if (emit_cnt_inc >= cfg.emit_period_ticks) begin
                        emit          = 1'b1;
                        emit_cnt_next = '0;
                    end else begin
                        emit_cnt_next = emit_cnt_inc;
                    end
                end
                REQ_TELEOP_CMD: begin
                    take_cmd = 1'b1;
                    cmd_idx  = CMD_TELEOP;
                end
                REQ_WEB_CMD: begin
                    take_cmd = 1'b1;
                    cmd_idx  = CMD_WEB;
                end
                REQ_AUTO_CMD: begin
                    take_cmd = 1'b1;
                    cmd_idx  = CMD_AUTO;
                end
                REQ_TELEOP_STS: begin
                    take_sts = 1'b1;
                    sts_idx  = MAN_TELEOP;
                end
                REQ_WEB_STS: begin
                    take_sts = 1'b1;
                    sts_idx  = MAN_WEB;
                end
                REQ_TELEOP_ESTOP: begin
                    tele_estop_next = item_reg.flag_value;
                end
                REQ_GATE: begin
                    gate_open_next = item_reg.flag_value;
                    gate_seen_next = 1'b1;
                end
                REQ_GLOBAL_ESTOP: begin
                    glob_estop_next = item_reg.flag_value;
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        // A non-finite command only drops the valid flag; value and age stay.
        if (take_cmd) begin
            cmd_valid_next[cmd_idx] = item_reg.cmd_finite;
            if (item_reg.cmd_finite) begin
                cmd_seen_next[cmd_idx] = 1'b1;
                cmd_age_next[cmd_idx]  = '0;
            end
        end

        // An active status, or a clean release of an active source, rearms the hold.
        if (take_sts) begin
            sts_code_next[sts_idx]   = item_reg.status_code;
            sts_seen_next[sts_idx]   = 1'b1;
            sts_age_next[sts_idx]    = '0;
            src_active_next[sts_idx] = sts_act;
            if (sts_act || (src_active_reg[sts_idx] && item_reg.status_code == STS_IDLE)) begin
                hold_armed_next[sts_idx] = 1'b1;
                hold_age_next[sts_idx]   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cmd_valid_reg  <= '0;
            cmd_seen_reg   <= '0;
            sts_seen_reg   <= '0;
            src_active_reg <= '0;
            hold_armed_reg <= '0;
            tele_estop_reg <= 1'b0;
            glob_estop_reg <= 1'b0;
            gate_open_reg  <= 1'b0;
            gate_seen_reg  <= 1'b0;
            emit_cnt_reg   <= '0;
            for (int i = 0; i < 3; i++) begin
                cmd_age_reg[i] <= '0;
            end
            for (int i = 0; i < 2; i++) begin
                sts_code_reg[i] <= STS_IDLE;
                sts_age_reg[i]  <= '0;
                hold_age_reg[i] <= '0;
            end
        end else begin
            cmd_valid_reg  <= cmd_valid_next;
            cmd_seen_reg   <= cmd_seen_next;
            sts_seen_reg   <= sts_seen_next;
            src_active_reg <= src_active_next;
            hold_armed_reg <= hold_armed_next;
            tele_estop_reg <= tele_estop_next;
            glob_estop_reg <= glob_estop_next;
            gate_open_reg  <= gate_open_next;
            gate_seen_reg  <= gate_seen_next;
            emit_cnt_reg   <= emit_cnt_next;
            for (int i = 0; i < 3; i++) begin
                cmd_age_reg[i] <= cmd_age_next[i];
            end
            for (int i = 0; i < 2; i++) begin
                sts_code_reg[i] <= sts_code_next[i];
                sts_age_reg[i]  <= sts_age_next[i];
                hold_age_reg[i] <= hold_age_next[i];
            end
        end
    end

    // Stored commands are only read once their seen flag is set, so they need no reset.
    always_ff @(posedge aclk) begin
        if (take_cmd && item_reg.cmd_finite) begin
            cmd_lin_reg[cmd_idx] <= VEL_WIDTH'($unsigned(item_reg.lin_vel));
            cmd_ang_reg[cmd_idx] <= VEL_WIDTH'($unsigned(item_reg.ang_vel));
        end
    end

    // Priority selection on the state as it stands after this tick's ageing.
    logic sf0, sf1, estop, tele_act, web_act, tele_hold, web_hold, gate_ok;
    logic c0, c1, c2;
    logic pick_valid;
    logic [1:0] pick_idx;
    logic [3:0] code;

    always_comb begin
        sf0 = sts_seen_next[0] && within_limit(sts_age_next[0], cfg.manual_timeout_ticks);
        sf1 = sts_seen_next[1] && within_limit(sts_age_next[1], cfg.manual_timeout_ticks);
        estop = glob_estop_next || tele_estop_next ||
                (sf0 && sts_code_next[0] == STS_ESTOP) ||
                (sf1 && sts_code_next[1] == STS_ESTOP);
        tele_act  = sf0 && (sts_code_next[0] >= STS_ACTIVE);
        web_act   = sf1 && (sts_code_next[1] >= STS_ACTIVE);
        tele_hold = hold_armed_next[0] &&
                    within_limit(hold_age_next[0], cfg.release_hold_ticks);
        web_hold  = hold_armed_next[1] &&
                    within_limit(hold_age_next[1], cfg.release_hold_ticks);
        gate_ok   = gate_seen_next && gate_open_next;
        c0 = cmd_valid_next[0] && cmd_seen_next[0] &&
             within_limit(cmd_age_next[0], cfg.manual_timeout_ticks);
        c1 = cmd_valid_next[1] && cmd_seen_next[1] &&
             within_limit(cmd_age_next[1], cfg.manual_timeout_ticks);
        c2 = cmd_valid_next[2] && cmd_seen_next[2] &&
             within_limit(cmd_age_next[2], cfg.autonomy_timeout_ticks);

        pick_valid = 1'b0;
        pick_idx   = CMD_TELEOP;
        if (estop) begin
            code = SRC_ESTOP;
        end else if (tele_act) begin
            code       = c0 ? SRC_TELEOP : SRC_TELEOP_STALE;
            pick_valid = c0;
            pick_idx   = CMD_TELEOP;
        end else if (tele_hold) begin
            code = SRC_TELEOP_HOLD;
        end else if (gate_ok) begin
            code       = c2 ? SRC_AUTO : SRC_AUTO_STALE;
            pick_valid = c2;
            pick_idx   = CMD_AUTO;
        end else if (web_act) begin
            code       = c1 ? SRC_WEB : SRC_WEB_STALE;
            pick_valid = c1;
            pick_idx   = CMD_WEB;
        end else if (web_hold) begin
            code = SRC_WEB_HOLD;
        end else begin
            code = SRC_GATE_CLOSED;
        end

        res.source_code = code;
        if (pick_valid) begin
            res.out_lin_vel = 16'(cmd_lin_reg[pick_idx]);
            res.out_ang_vel = 16'(cmd_ang_reg[pick_idx]);
        end else begin
            res.out_lin_vel = '0;
            res.out_ang_vel = '0;
        end
    end

    assign res_push = emit;

endmodule

`default_nettype wire

[rtl/core/vcpm_out_buf.sv]
// Two-entry result buffer that drives the master stream side.
// Lets the event path keep running while results wait. Depends on vcpm_pkg.
`default_nettype none

module vcpm_out_buf
    import vcpm_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  push,
    input  result_t    push_data,
    input  wire logic  m_tready,
    output logic       m_tvalid,
    output result_t    m_data,
    output logic [1:0] level
);

    result_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;
    logic       pop;

    assign m_tvalid = count_reg != 2'd0;
    assign m_data   = slot_reg[rd_ptr_reg];
    assign pop      = m_tvalid && m_tready;
    assign level    = count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

[rtl/core/velocity_command_priority_mux.sv]
// An emitting tick passes the event register and its result is then registered in the buffer.
// Throughput: one input transaction per cycle; s_tready falls only while the two-entry result
// buffer and the event register together already account for two results.
// Reset: aresetn is synchronous and active low; it clears all source state, flags, ages and the
// emit counter and returns the registers to 300, 600, 1000 and 20 ticks.
`default_nettype none

module velocity_command_priority_mux
    import vcpm_pkg::*;
#(
    parameter int VEL_WIDTH = 16,
    parameter int AGE_WIDTH = 11
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    // Event stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // tdata from bit 0: lin_vel[15:0], ang_vel[31:16], cmd_finite[32], status_code[34:33],
    // flag_value[35], zero padding[39:36].
    input  wire logic [39:0] s_tdata,
    // tuser from bit 0: req_type[3:0].
    input  wire logic [3:0]  s_tuser,

    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tdata from bit 0: out_lin_vel[15:0], out_ang_vel[31:16], source_code[35:32],
    // zero padding[39:36].
    output logic      [39:0] m_tdata,

    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    cfg_t       cfg;
    item_t      item;
    result_t    res;
    result_t    m_res;
    logic       item_load;
    logic       item_pending;
    logic       res_push;
    logic [1:0] level;
    logic [2:0] credit_used;

    // The register block holds the four limits; software must write them only while the
    // block is idle. The block itself does not enforce this; the event path uses them directly.
    vcpm_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Unpack the event transaction.
    always_comb begin
        item.req_type    = s_tuser;
        item.lin_vel     = s_tdata[15:0];
        item.ang_vel     = s_tdata[31:16];
        item.cmd_finite  = s_tdata[32];
        item.status_code = s_tdata[34:33];
        item.flag_value  = s_tdata[35];
    end

    // Every event may yield at most one result. An event is accepted only when the
    // buffer can still take a result from it and from the event already registered,
    // so the buffer never overflows and no result is lost.
    assign credit_used = 3'(level) + 3'(item_pending);
    assign s_tready    = credit_used < 3'd2;
    assign item_load   = s_tvalid && s_tready;

    // The event register, source state and priority selection sit in the core; the
    // result of an emitting tick leaves it combinationally and is registered in the buffer.
    vcpm_core #(
        .VEL_WIDTH (VEL_WIDTH),
        .AGE_WIDTH (AGE_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .item_load    (item_load),
        .item_in      (item),
        .cfg          (cfg),
        .item_pending (item_pending),
        .res_push     (res_push),
        .res          (res)
    );

    vcpm_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (res_push),
        .push_data (res),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_data    (m_res),
        .level     (level)
    );

    // Pack the result transaction.
    assign m_tdata = {4'd0, m_res.source_code, m_res.out_ang_vel, m_res.out_lin_vel};

endmodule

`default_nettype wire

[rtl/core/vcpm_checker.sv]
// Port-level checker for the velocity command priority multiplexer, with its bind.
// Depends on the top level's port list only.
`default_nettype none

module vcpm_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // A waiting result keeps its contents until it is taken.
    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only a chosen fresh source may carry a non-zero velocity.
    a_zero_unless_chosen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !(m_tdata[35:32] == 4'd1 || m_tdata[35:32] == 4'd4 ||
                      m_tdata[35:32] == 4'd6) |-> m_tdata[31:0] == 32'd0)
        else $error("velocity present for a stale, held or stopped choice");

    // Reset leaves no result pending.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result pending after reset");

    // With nothing buffered and nothing taken last cycle, the event side is open.
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(aresetn) && !m_tvalid && !$past(s_tvalid && s_tready) |-> s_tready)
        else $error("event side stalled with nothing in flight");

endmodule

bind velocity_command_priority_mux vcpm_checker u_vcpm_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
